[design/pimp_pkg.sv]
// ----------------------------------------------------------------------------
// pimp_pkg: shared types and constants of the polyline interval marker placer
// Beat types for both channels and the command and result bundles that
// travel between the sequencer and the shared arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pimp_pkg;

   localparam int SPACING_W           = 31;
   localparam logic [SPACING_W-1:0] SPACING_RESET = 31'd65536;
   localparam int MAX_MARKERS_DEFAULT = 32;
   localparam int FRAC_BITS_DEFAULT   = 16;

   // Operand and accumulator widths of the arithmetic unit.
   localparam int OPND_W     = 34;
   localparam int ACC_W      = 66;
   localparam int SQRT_STEPS = 33;
   localparam int DIV_STEPS  = 66;

   typedef struct packed {
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] vz;
      logic               final_vertex;
      logic               closed_ring;
   } req_type;

   typedef struct packed {
      logic signed [31:0] mx;
      logic signed [31:0] my;
      logic signed [31:0] mz;
      logic               run_end;
      logic               truncated;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_MAC,
      OP_SQRT,
      OP_DIV
   } arith_op_type;

   // For OP_MAC fresh clears the accumulator; for OP_DIV it loads a as dividend.
   typedef struct packed {
      logic                start;
      arith_op_type        op;
      logic                fresh;
      logic [OPND_W-1:0]   a;
      logic [OPND_W-1:0]   b;
   } arith_cmd_type;

   typedef struct packed {
      logic                done;
      logic [OPND_W-1:0]   quot;
      logic [OPND_W-1:0]   rem;
   } arith_rsp_type;

endpackage

`default_nettype wire

[design/pimp_arith.sv]
// ----------------------------------------------------------------------------
// pimp_arith: shared shift-add multiplier, square root and divider
// One bit per cycle. Multiplies accumulate into a 66-bit register, which is
// also the radicand of the square root and the dividend of the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module pimp_arith
   import pimp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire arith_cmd_type cmd,
   output arith_rsp_type      rsp
);

   localparam int CNT_W = $clog2(DIV_STEPS + 1);

   typedef enum logic [1:0] {
      U_IDLE,
      U_MAC,
      U_SQRT,
      U_DIV
   } ustate_type;

   ustate_type         state_ff;
   logic               done_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic [ACC_W-1:0]   aux_ff;
   logic [OPND_W-1:0]  bsh_ff;
   logic [35:0]        rem_ff;
   logic [OPND_W-1:0]  q_ff;
   logic [CNT_W-1:0]   cnt_ff;

   logic [35:0] sq_sh, sq_trial, dv_sh;
   logic        sq_ge, dv_ge;

   // Restoring square root: two radicand bits per step.
   assign sq_sh    = {rem_ff[33:0], acc_ff[ACC_W-1 -: 2]};
   assign sq_trial = {1'b0, q_ff[32:0], 2'b01};
   assign sq_ge    = (sq_sh >= sq_trial);

   // Restoring division: one dividend bit per step.
   assign dv_sh = {rem_ff[34:0], acc_ff[ACC_W-1]};
   assign dv_ge = (dv_sh >= {2'b00, bsh_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            U_IDLE: begin
               if (cmd.start) begin
                  case (cmd.op)
                     OP_MAC: begin
                        if (cmd.fresh) begin
                           acc_ff <= '0;
                        end
                        aux_ff   <= ACC_W'(cmd.a);
                        bsh_ff   <= cmd.b;
                        state_ff <= U_MAC;
                     end
                     OP_SQRT: begin
                        rem_ff   <= '0;
                        q_ff     <= '0;
                        cnt_ff   <= CNT_W'(SQRT_STEPS);
                        state_ff <= U_SQRT;
                     end
                     OP_DIV: begin
                        if (cmd.fresh) begin
                           acc_ff <= ACC_W'(cmd.a);
                        end
                        bsh_ff   <= cmd.b;
                        rem_ff   <= '0;
                        q_ff     <= '0;
                        cnt_ff   <= CNT_W'(DIV_STEPS);
                        state_ff <= U_DIV;
                     end
                     default: begin
                        done_ff <= 1'b1;
                     end
                  endcase
               end
            end
            U_MAC: begin
               if (bsh_ff == '0) begin
                  done_ff  <= 1'b1;
                  state_ff <= U_IDLE;
               end else begin
                  if (bsh_ff[0]) begin
                     acc_ff <= acc_ff + aux_ff;
                  end
                  aux_ff <= aux_ff << 1;
                  bsh_ff <= bsh_ff >> 1;
               end
            end
            U_SQRT: begin
               rem_ff <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
               q_ff   <= {q_ff[OPND_W-2:0], sq_ge};
               acc_ff <= acc_ff << 2;
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  done_ff  <= 1'b1;
                  state_ff <= U_IDLE;
               end
            end
            U_DIV: begin
               rem_ff <= dv_ge ? (dv_sh - {2'b00, bsh_ff}) : dv_sh;
               q_ff   <= {q_ff[OPND_W-2:0], dv_ge};
               acc_ff <= acc_ff << 1;
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  done_ff  <= 1'b1;
                  state_ff <= U_IDLE;
               end
            end
            default: begin
               state_ff <= U_IDLE;
            end
         endcase
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = q_ff;
   assign rsp.rem  = rem_ff[OPND_W-1:0];

endmodule

`default_nettype wire

[design/polyline_interval_marker_placer_core.sv]
// ----------------------------------------------------------------------------
// polyline_interval_marker_placer_core: fixed-spacing markers along polylines
// Takes one vertex per beat and gives markers at fixed arc-length spacing.
// ----------------------------------------------------------------------------
// Each vertex beat is worked through by a sequencer that drives one shared
// bit-serial unit (multiply, square root, divide), so the block takes one
// vertex at a time and is not ready until the vertex's last marker has moved
// into the output register. A segment takes three multiplies for the
// squared length, a root and a divide for the marker count; each marker
// then takes a multiply and a divide for each of its three coordinates. The
// first vertex of a line runs no segment of its own, a ring's last vertex runs two
// segments. A marker waits in one holding register until the next one is
// known, so the last marker of a beat can carry run_end.
`default_nettype none

module polyline_interval_marker_placer_core
   import pimp_pkg::*;
#(
   parameter int MAX_MARKERS_PER_SEGMENT = MAX_MARKERS_DEFAULT,
   parameter int FRAC_BITS               = FRAC_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [SPACING_W-1:0] csr_wdata
);

   localparam int KW = $clog2(MAX_MARKERS_PER_SEGMENT + 1);
   localparam int PW = SPACING_W + KW;
   localparam logic [SPACING_W-1:0] ONE = SPACING_W'(1) << FRAC_BITS;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RING,
      S_SQ,
      S_ROOT,
      S_DIVN,
      S_MARK,
      S_MUL,
      S_DIVQ,
      S_PUT,
      S_SEGEND,
      S_FLUSH
   } state_type;

   state_type                 state_ff;
   logic                      go_ff;
   logic [SPACING_W-1:0]      spacing_ff;
   logic signed [31:0]        prev_ff   [3];
   logic signed [31:0]        origin_ff [3];
   logic signed [31:0]        cur_ff    [3];
   logic signed [31:0]        seg_s_ff  [3];
   logic signed [31:0]        seg_e_ff  [3];
   logic signed [31:0]        mk_ff     [3];
   logic [31:0]               carried_ff;
   logic                      line_start_ff;
   logic                      fin_ff;
   logic                      ring_ff;
   logic                      closing_ff;
   logic [1:0]                axis_ff;
   logic [32:0]               len_ff;
   logic [31:0]               before_ff;
   logic [KW-1:0]             k_ff;
   logic [KW-1:0]             j_ff;
   logic                      trunc_ff;
   logic [PW-1:0]             pos_ff;
   rsp_type                   pend_ff;
   logic                      pend_valid_ff;
   rsp_type                   out_ff;
   logic                      out_valid_ff;

   arith_cmd_type             cmd;
   arith_rsp_type             ars;

   logic [SPACING_W-1:0]      step;
   logic signed [32:0]        d_axis;
   logic                      d_neg;
   logic [OPND_W-1:0]         d_mag;
   logic signed [PW:0]        t_full;
   logic                      t_neg;
   logic [PW:0]               t_abs;
   logic [OPND_W-1:0]         t_mag;
   logic [33:0]               total;
   logic [31:0]               m_lo;
   logic [31:0]               coord;
   logic                      out_free;
   logic                      out_load;
   logic                      more_than_max;
   rsp_type                   new_marker;

   assign step = (spacing_ff == '0) ? ONE : spacing_ff;

   assign d_axis = {seg_e_ff[axis_ff][31], seg_e_ff[axis_ff]}
                 - {seg_s_ff[axis_ff][31], seg_s_ff[axis_ff]};
   assign d_neg  = d_axis[32];
   assign d_mag  = OPND_W'(d_neg ? -d_axis : d_axis);

   // Distance of the current marker from the segment start; may be negative
   // when the carried distance exceeds the spacing.
   assign t_full = $signed({1'b0, pos_ff}) - $signed({{(PW + 1 - 32){1'b0}}, before_ff});
   assign t_neg  = t_full[PW];
   assign t_abs  = t_neg ? -t_full : t_full;
   assign t_mag  = t_abs[OPND_W-1:0];

   assign total = {2'b00, carried_ff} + {1'b0, len_ff};

   assign m_lo  = ars.quot[31:0];
   assign coord = seg_s_ff[axis_ff] + ((d_neg ^ t_neg) ? -m_lo : m_lo);

   assign out_free      = !out_valid_ff || rsp_ready;
   assign out_load      = pend_valid_ff && out_free
                        && ((state_ff == S_PUT) || (state_ff == S_FLUSH));
   assign more_than_max = (ars.quot > OPND_W'(MAX_MARKERS_PER_SEGMENT));

   assign new_marker = '{mx: mk_ff[0], my: mk_ff[1], mz: mk_ff[2],
                         run_end: 1'b0, truncated: trunc_ff};

   always_comb begin
      cmd       = '0;
      cmd.start = go_ff;
      cmd.op    = OP_MAC;
      case (state_ff)
         S_SQ: begin
            cmd.op    = OP_MAC;
            cmd.fresh = (axis_ff == 2'd0);
            cmd.a     = d_mag;
            cmd.b     = d_mag;
         end
         S_ROOT: begin
            cmd.op = OP_SQRT;
         end
         S_DIVN: begin
            cmd.op    = OP_DIV;
            cmd.fresh = 1'b1;
            cmd.a     = total;
            cmd.b     = OPND_W'(step);
         end
         S_MUL: begin
            cmd.op    = OP_MAC;
            cmd.fresh = 1'b1;
            cmd.a     = d_mag;
            cmd.b     = t_mag;
         end
         S_DIVQ: begin
            cmd.op = OP_DIV;
            cmd.b  = OPND_W'(len_ff);
         end
         default: begin
            cmd.start = 1'b0;
         end
      endcase
   end

   pimp_arith u_arith (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .rsp   (ars)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         go_ff         <= 1'b0;
         spacing_ff    <= SPACING_RESET;
         carried_ff    <= '0;
         line_start_ff <= 1'b1;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            prev_ff[i]   <= '0;
            origin_ff[i] <= '0;
         end
      end else begin
         go_ff <= 1'b0;
         if (csr_we) begin
            spacing_ff <= csr_wdata;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cur_ff[0]  <= req_data.vx;
                  cur_ff[1]  <= req_data.vy;
                  cur_ff[2]  <= req_data.vz;
                  fin_ff     <= req_data.final_vertex;
                  ring_ff    <= req_data.closed_ring;
                  prev_ff[0] <= req_data.vx;
                  prev_ff[1] <= req_data.vy;
                  prev_ff[2] <= req_data.vz;
                  seg_s_ff   <= prev_ff;
                  seg_e_ff[0] <= req_data.vx;
                  seg_e_ff[1] <= req_data.vy;
                  seg_e_ff[2] <= req_data.vz;
                  closing_ff <= 1'b0;
                  axis_ff    <= 2'd0;
                  if (line_start_ff) begin
                     pend_ff       <= '{mx: req_data.vx, my: req_data.vy, mz: req_data.vz,
                                        run_end: 1'b0, truncated: 1'b0};
                     pend_valid_ff <= 1'b1;
                     origin_ff[0]  <= req_data.vx;
                     origin_ff[1]  <= req_data.vy;
                     origin_ff[2]  <= req_data.vz;
                     carried_ff    <= '0;
                     line_start_ff <= 1'b0;
                     state_ff      <= S_RING;
                  end else begin
                     go_ff    <= 1'b1;
                     state_ff <= S_SQ;
                  end
               end
            end
            S_RING: begin
               if (fin_ff && ring_ff) begin
                  seg_s_ff   <= cur_ff;
                  seg_e_ff   <= origin_ff;
                  closing_ff <= 1'b1;
                  axis_ff    <= 2'd0;
                  go_ff      <= 1'b1;
                  state_ff   <= S_SQ;
               end else begin
                  state_ff <= S_FLUSH;
               end
            end
            S_SQ: begin
               if (ars.done) begin
                  go_ff <= 1'b1;
                  if (axis_ff == 2'd2) begin
                     state_ff <= S_ROOT;
                  end else begin
                     axis_ff <= axis_ff + 2'd1;
                  end
               end
            end
            S_ROOT: begin
               if (ars.done) begin
                  len_ff    <= ars.quot[32:0];
                  before_ff <= carried_ff;
                  go_ff     <= 1'b1;
                  state_ff  <= S_DIVN;
               end
            end
            S_DIVN: begin
               if (ars.done) begin
                  carried_ff <= ars.rem[31:0];
                  trunc_ff   <= more_than_max;
                  k_ff       <= more_than_max ? KW'(MAX_MARKERS_PER_SEGMENT)
                                              : ars.quot[KW-1:0];
                  j_ff       <= '0;
                  pos_ff     <= PW'(step);
                  state_ff   <= (ars.quot == '0) ? S_SEGEND : S_MARK;
               end
            end
            S_MARK: begin
               axis_ff <= 2'd0;
               // A segment of zero length puts every owed marker at its start.
               if (len_ff == '0) begin
                  mk_ff    <= seg_s_ff;
                  state_ff <= S_PUT;
               end else begin
                  go_ff    <= 1'b1;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               if (ars.done) begin
                  go_ff    <= 1'b1;
                  state_ff <= S_DIVQ;
               end
            end
            S_DIVQ: begin
               if (ars.done) begin
                  mk_ff[axis_ff] <= coord;
                  if (axis_ff == 2'd2) begin
                     state_ff <= S_PUT;
                  end else begin
                     axis_ff  <= axis_ff + 2'd1;
                     go_ff    <= 1'b1;
                     state_ff <= S_MUL;
                  end
               end
            end
            S_PUT: begin
               if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     out_ff <= pend_ff;
                  end
                  pend_ff       <= new_marker;
                  pend_valid_ff <= 1'b1;
                  j_ff          <= j_ff + 1'b1;
                  pos_ff        <= pos_ff + PW'(step);
                  state_ff      <= ((j_ff + 1'b1) == k_ff) ? S_SEGEND : S_MARK;
               end
            end
            S_SEGEND: begin
               state_ff <= closing_ff ? S_FLUSH : S_RING;
            end
            S_FLUSH: begin
               if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     out_ff        <= '{mx: pend_ff.mx, my: pend_ff.my, mz: pend_ff.mz,
                                        run_end: 1'b1, truncated: pend_ff.truncated};
                     pend_valid_ff <= 1'b0;
                  end
                  if (fin_ff) begin
                     line_start_ff <= 1'b1;
                     carried_ff    <= '0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

[design/pimp_checker.sv]
// ----------------------------------------------------------------------------
// pimp_checker: port-level checks of the marker placer
// Watches the top level's ports only and is bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

module pimp_checker
   import pimp_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire req_type              req_data,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire rsp_type              rsp_data,
   input wire logic                 csr_we,
   input wire logic [SPACING_W-1:0] csr_wdata
);

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // One vertex at a time: after taking a beat the block is busy.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken on two cycles in a row");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat valid after reset");

   // A vertex is never taken while a result beat of it is still owed in the
   // holding path: a fresh accept never meets a result beat that is not
   // the closing one of its run.
   a_run_closed: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && rsp_valid |-> rsp_data.run_end)
      else $error("new vertex taken before previous run was closed");

endmodule

bind polyline_interval_marker_placer_core pimp_checker u_pimp_checker (.*);

`default_nettype wire

[tb/polyline_interval_marker_placer_core_tb.sv]
// ----------------------------------------------------------------------------
// polyline_interval_marker_placer_core_tb: self-checking marker placer bench
// Sends polylines vertex by vertex under random gaps and output stalls,
// predicts every marker with an exact fixed-point model of its own and
// compares each output beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module polyline_interval_marker_placer_core_tb;
   import pimp_pkg::*;

   localparam int MAX_PER_SEG = 32;
   localparam int FRAC        = 16;
   localparam int STALL_LIMIT = 100000;
   localparam int SETTLE      = 600;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [SPACING_W-1:0] csr_wdata = '0;

   // Shadow of the block's state.
   logic [30:0] spacing_q;
   logic [31:0] prev_q [3];
   logic [31:0] origin_q [3];
   logic [31:0] carried_q;
   logic        line_start_q;

   rsp_type pending_marks [$];
   rsp_type beat_marks [$];
   int      error_count = 0;
   int      stall_count = 0;
   bit      sender_busy_mode = 1'b0;
   bit      rsp_stall_mode = 1'b0;
   int      rsp_hold       = 0;

   polyline_interval_marker_placer_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic longint offset_along(longint d, longint t, logic [127:0] len);
      logic [127:0] prod;
      logic [63:0]  quot;
      if (len == 0) return 0;
      prod = 128'(d < 0 ? -d : d) * 128'(t < 0 ? -t : t);
      quot = 64'(prod / len);
      return ((d < 0) != (t < 0)) ? -longint'(quot) : longint'(quot);
   endfunction

   task automatic place_on_segment(input longint s [3], input longint e [3]);
      longint       d [3];
      longint       t;
      longint       pos [3];
      logic [127:0] sq;
      logic [127:0] len;
      logic [127:0] cand;
      logic [127:0] step;
      logic [127:0] owed;
      logic [127:0] total;
      logic [127:0] count;
      logic [127:0] placed;
      bit           trunc;
      rsp_type      m;
      sq = '0;
      for (int a = 0; a < 3; a++) begin
         d[a] = e[a] - s[a];
         sq += 128'(d[a] < 0 ? -d[a] : d[a]) * 128'(d[a] < 0 ? -d[a] : d[a]);
      end
      len = '0;
      for (int b = 40; b >= 0; b--) begin
         cand = len | (128'(1) << b);
         if (cand * cand <= sq) len = cand;
      end
      step  = (spacing_q == 0) ? (128'(1) << FRAC) : 128'(spacing_q);
      owed  = 128'(carried_q);
      total = owed + len;
      if (total < step) begin
         carried_q = total[31:0];
         return;
      end
      count     = total / step;
      carried_q = 32'(total % step);
      trunc     = count > MAX_PER_SEG;
      placed    = trunc ? MAX_PER_SEG : count;
      for (int j = 0; j < placed; j++) begin
         t = longint'(64'((j + 1) * step)) - longint'(owed);
         for (int a = 0; a < 3; a++)
            pos[a] = s[a] + offset_along(d[a], t, len);
         m.mx        = pos[0][31:0];
         m.my        = pos[1][31:0];
         m.mz        = pos[2][31:0];
         m.run_end   = 1'b0;
         m.truncated = trunc;
         beat_marks.push_back(m);
      end
   endtask

   task automatic predict_vertex(input req_type v);
      longint  cur [3];
      longint  s [3];
      rsp_type m;
      cur[0] = longint'(v.vx);
      cur[1] = longint'(v.vy);
      cur[2] = longint'(v.vz);
      beat_marks.delete();
      if (line_start_q) begin
         m = '{mx: v.vx, my: v.vy, mz: v.vz, run_end: 1'b0, truncated: 1'b0};
         beat_marks.push_back(m);
         for (int a = 0; a < 3; a++) origin_q[a] = cur[a][31:0];
         carried_q    = '0;
         line_start_q = 1'b0;
      end else begin
         for (int a = 0; a < 3; a++) s[a] = longint'(signed'(prev_q[a]));
         place_on_segment(s, cur);
      end
      if (v.final_vertex && v.closed_ring) begin
         for (int a = 0; a < 3; a++) s[a] = longint'(signed'(origin_q[a]));
         place_on_segment(cur, s);
      end
      for (int a = 0; a < 3; a++) prev_q[a] = cur[a][31:0];
      if (v.final_vertex) begin
         line_start_q = 1'b1;
         carried_q    = '0;
      end
      if (beat_marks.size() > 0) beat_marks[$].run_end = 1'b1;
      foreach (beat_marks[i]) pending_marks.push_back(beat_marks[i]);
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report(input string what, input longint want, input longint got);
      $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_marks.size() == 0) begin
            report("unexpected marker beat", 0, longint'(rsp_data));
         end else begin
            want = pending_marks.pop_front();
            if (rsp_data.mx !== want.mx) report("mx", want.mx, rsp_data.mx);
            if (rsp_data.my !== want.my) report("my", want.my, rsp_data.my);
            if (rsp_data.mz !== want.mz) report("mz", want.mz, rsp_data.mz);
            if (rsp_data.run_end !== want.run_end)
               report("run_end", want.run_end, rsp_data.run_end);
            if (rsp_data.truncated !== want.truncated)
               report("truncated", want.truncated, rsp_data.truncated);
         end
      end
   end

   // Receiver alternates between stretches of steady acceptance and random stalls.
   always @(posedge clock) begin
      int pick;
      if ($urandom_range(0, 199) == 0) rsp_stall_mode = ~rsp_stall_mode;
      if (!rsp_stall_mode) begin
         rsp_ready <= 1'b1;
      end else if (rsp_hold > 0) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_ready <= 1'b0;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            rsp_ready <= 1'b1;
         end else if (pick < 92) begin
            rsp_hold  <= $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_hold  <= $urandom_range(10, 60);
            rsp_ready <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   // ---------------------------------------------------------------- driving

   function automatic int pick_gap();
      int r;
      if (!sender_busy_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_vertex(input longint x, input longint y, input longint z,
                              input bit fin, input bit ring);
      req_type v;
      int      gap;
      v.vx = x[31:0];
      v.vy = y[31:0];
      v.vz = z[31:0];
      v.final_vertex = fin;
      v.closed_ring  = ring;
      if ($urandom_range(0, 59) == 0) sender_busy_mode = ~sender_busy_mode;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= v;
      do @(posedge clock); while (!req_ready);
      predict_vertex(v);
   endtask

   // Waits for the block to go quiet, then writes the spacing register.
   task automatic write_spacing(input logic [30:0] value);
      req_valid <= 1'b0;
      while (pending_marks.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      spacing_q  = value;
   endtask

   // ---------------------------------------------------------------- tests

   localparam longint ONE = 64'sd65536;

   task automatic test_line_start_and_single();
      send_vertex(0, 0, 0, 1'b1, 1'b0);
      send_vertex(ONE, -ONE, 3, 1'b1, 1'b1);
      send_vertex(0, 0, 0, 1'b0, 1'b1);
      send_vertex(3 * ONE, 4 * ONE, 0, 1'b0, 1'b0);
      send_vertex(3 * ONE, 4 * ONE, 12 * ONE + 100, 1'b1, 1'b0);
   endtask

   task automatic test_extremes();
      write_spacing(31'h7FFF_FFFF);
      send_vertex(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 1'b0);
      send_vertex(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000, 1'b0, 1'b0);
      send_vertex(32'sh7FFF_FFFF, -64'sh8000_0000, 0, 1'b1, 1'b1);
   endtask

   task automatic test_zero_spacing();
      write_spacing('0);
      send_vertex(-5 * ONE, 0, 0, 1'b0, 1'b0);
      send_vertex(-2 * ONE + 17, ONE / 2, 0, 1'b1, 1'b0);
   endtask

   task automatic test_saturated_segment();
      write_spacing(31'(ONE));
      send_vertex(0, 0, 0, 1'b0, 1'b0);
      send_vertex(40 * ONE, 0, 0, 1'b0, 1'b0);
      send_vertex(40 * ONE, 0, -70 * ONE, 1'b1, 1'b0);
   endtask

   task automatic test_ring_closure();
      send_vertex(ONE, ONE, 0, 1'b0, 1'b0);
      send_vertex(3 * ONE, ONE, 0, 1'b0, 1'b0);
      send_vertex(3 * ONE, 3 * ONE + ONE / 3, 0, 1'b1, 1'b1);
   endtask

   // Carry left over from a wide spacing lands on a zero-length segment.
   task automatic test_spacing_change_midline();
      write_spacing(31'(10 * ONE));
      send_vertex(0, 0, 0, 1'b0, 1'b0);
      send_vertex(9 * ONE + ONE / 2, 0, 0, 1'b0, 1'b0);
      write_spacing(31'(ONE));
      send_vertex(9 * ONE + ONE / 2, 0, 0, 1'b0, 1'b0);
      write_spacing(31'(10 * ONE));
      send_vertex(9 * ONE, 0, 2 * ONE, 1'b0, 1'b0);
      write_spacing(31'(ONE / 4));
      send_vertex(9 * ONE, ONE, 2 * ONE, 1'b1, 1'b0);
   endtask

   task automatic test_random_lines(input int item_target);
      logic [30:0] spacing_set [6];
      longint      pos [3];
      longint      reach;
      int          sent;
      int          verts;
      bit          fin;
      spacing_set = '{31'd0, 31'd65536, 31'd1000, 31'h10_0000, 31'h7FFF_FFFF, 31'd300};
      sent = 0;
      while (sent < item_target) begin
         if ($urandom_range(0, 9) == 0)
            write_spacing(spacing_set[$urandom_range(0, 5)]);
         reach = (spacing_q == 0) ? ONE : longint'(spacing_q);
         if (reach > 64'sd1073741824) reach = 64'sd1073741824;
         for (int a = 0; a < 3; a++) pos[a] = longint'(signed'(32'($urandom())));
         verts = $urandom_range(1, 6);
         for (int i = 0; i < verts; i++) begin
            fin = (i == verts - 1);
            send_vertex(pos[0], pos[1], pos[2], fin, 1'($urandom_range(0, 1)));
            sent++;
            for (int a = 0; a < 3; a++) begin
               if ($urandom_range(0, 99) < 2)
                  pos[a] = longint'(signed'(32'($urandom())));
               else if ($urandom_range(0, 1))
                  pos[a] = longint'(signed'(32'(pos[a] + $urandom_range(0, 32'(reach)))));
               else
                  pos[a] = longint'(signed'(32'(pos[a] - $urandom_range(0, 32'(reach)))));
            end
         end
      end
   endtask

   initial begin
      spacing_q    = SPACING_RESET;
      carried_q    = '0;
      line_start_q = 1'b1;
      for (int a = 0; a < 3; a++) begin
         prev_q[a]   = '0;
         origin_q[a] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_line_start_and_single();
      test_extremes();
      test_zero_spacing();
      test_saturated_segment();
      test_ring_closure();
      test_spacing_change_midline();
      test_random_lines(480);
      req_valid <= 1'b0;
      while (pending_marks.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
